// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check of a property on the rising clock edge, off during reset.
`define RCI_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent check that a condition never holds.
`define RCI_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ----- rtl/rci_pkg.sv -----
`default_nettype none

package rci_pkg;

   // default fraction bits of the Q formats
   localparam int FRAC_BITS = 16;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] t_min;
      logic signed [31:0] t_max;
      logic        [30:0] radius;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] t_hit;
      logic signed [31:0] hit_x;
      logic signed [31:0] hit_y;
      logic signed [31:0] normal_x;
      logic signed [31:0] normal_y;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/rci_sqrt_cell.sv -----
`default_nettype none

// One digit of a restoring integer square root; two radicand bits per cell.
module rci_sqrt_cell #(
   parameter int QW = 32,
   parameter int NW = 64,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [QW+1:0] in_rem,
   input  logic [QW-1:0] in_root,
   input  logic [NW-1:0] in_rad,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [QW+1:0] out_rem,
   output logic [QW-1:0] out_root,
   output logic [NW-1:0] out_rad,
   output logic [SW-1:0] out_side
);

   logic          valid_ff;
   logic [QW+1:0] rem_sh, trial, rem_in, rem_ff;
   logic [QW-1:0] root_in, root_ff;
   logic [NW-1:0] rad_in, rad_ff;
   logic [SW-1:0] side_ff;
   logic          take;

   always_comb begin
      rem_sh  = {in_rem[QW-1:0], in_rad[NW-1 -: 2]};
      trial   = {in_root, 2'b01};
      take    = (rem_sh >= trial);
      rem_in  = take ? (rem_sh - trial) : rem_sh;
      root_in = {in_root[QW-2:0], take};
      rad_in  = {in_rad[NW-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
      rad_ff  <= rad_in;
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_rad   = rad_ff;
   assign out_side  = side_ff;

endmodule

`default_nettype wire

// ----- rtl/rci_div_cell.sv -----
`default_nettype none

// One quotient bit of a restoring divide, LN lanes sharing one divisor.
// Each lane's nq word shifts dividend bits out at the top, quotient bits in below.
module rci_div_cell #(
   parameter int DW = 32,
   parameter int NW = 31,
   parameter int LN = 2,
   parameter int SW = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [DW-1:0]          in_div,
   input  logic [LN-1:0][DW-1:0]  in_rem,
   input  logic [LN-1:0][NW-1:0]  in_nq,
   input  logic [SW-1:0]          in_side,
   output logic                   out_valid,
   output logic [DW-1:0]          out_div,
   output logic [LN-1:0][DW-1:0]  out_rem,
   output logic [LN-1:0][NW-1:0]  out_nq,
   output logic [SW-1:0]          out_side
);

   logic                  valid_ff;
   logic [DW-1:0]         div_ff;
   logic [LN-1:0][DW:0]   trial, diff;
   logic [LN-1:0]         take;
   logic [LN-1:0][DW-1:0] rem_in, rem_ff;
   logic [LN-1:0][NW-1:0] nq_in, nq_ff;
   logic [SW-1:0]         side_ff;

   always_comb begin
      for (int l = 0; l < LN; l++) begin
         trial[l]  = {in_rem[l], in_nq[l][NW-1]};
         diff[l]   = trial[l] - {1'b0, in_div};
         take[l]   = (trial[l] >= {1'b0, in_div});
         rem_in[l] = take[l] ? diff[l][DW-1:0] : trial[l][DW-1:0];
         nq_in[l]  = {in_nq[l][NW-2:0], take[l]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      div_ff  <= in_div;
      rem_ff  <= rem_in;
      nq_ff   <= nq_in;
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_div   = div_ff;
   assign out_rem   = rem_ff;
   assign out_nq    = nq_ff;
   assign out_side  = side_ff;

endmodule

`default_nettype wire

// ----- rtl/ray_circle_intersect.sv -----
// Ray segment against origin-centered circle, fully pipelined.
// Throughput is one transaction per cycle, from start to rsp_strobe.
// The pipe holds the 64-cell and 32-cell square-root rows and the 34-cell and 31-cell divider rows.
// busy is high only during reset; the receiver cannot stall, each result shows for one cycle.
// Synchronous active-high reset clears all valid bits; nothing in flight survives it.
`default_nettype none
`include "assert_macros.svh"

module ray_circle_intersect #(
   parameter int FRAC_BITS = rci_pkg::FRAC_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rci_pkg::req_type req_data,
   output logic             rsp_strobe,
   output rci_pkg::rsp_type rsp_data
);

   // cell counts of the rows
   localparam int SQ1 = 64;   // root of discriminant, 128-bit radicand
   localparam int DIV1 = 34;  // root quotients, bits 33..0
   localparam int SQ2 = 32;   // length of hit point, 64-bit radicand
   localparam int DIV2 = 31;  // normal quotients, bits 30..0
   localparam int LATENCY = 5 + SQ1 + 2 + DIV1 + 6 + SQ2 + 1 + DIV2 + 1;
   localparam int HI_SHIFT = 34 - FRAC_BITS;
   localparam logic [34:0] ROOT_LIMIT = 35'(64'd1 << 33);

   typedef struct packed {
      logic signed [31:0] ox, oy, dx, dy, tmin, tmax;
   } ray_type;

   typedef struct packed {
      logic signed [64:0] h;
      logic               miss;
      ray_type            ray;
   } sq1_side_type;

   typedef struct packed {
      logic               miss;
      logic [1:0]         neg;
      logic [1:0]         big;
      ray_type            ray;
   } div1_side_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] th, px, py;
   } sq2_side_type;

   typedef struct packed {
      logic               hit;
      logic               len_zero;
      logic [1:0]         neg;
      logic signed [31:0] th, px, py;
   } div2_side_type;

   localparam int SQ1W = $bits(sq1_side_type);
   localparam int DIV1W = $bits(div1_side_type);
   localparam int SQ2W = $bits(sq2_side_type);
   localparam int DIV2W = $bits(div2_side_type);

   logic accept;
   assign busy   = reset;
   assign accept = start && !busy;

   // valid bits of the glue stages
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   logic v8_ff, v9_ff, v10_ff, v11_ff, v12_ff, v13_ff, v14_ff, v15_ff;

   // ---- stage 1: 32x32 products from the transaction ----
   logic        [63:0] dxx_in, dyy_in, dxx_ff, dyy_ff;
   logic signed [63:0] oxdx_in, oydy_in, oxdy_in, oydx_in;
   logic signed [63:0] oxdx_ff, oydy_ff, oxdy_ff, oydx_ff;
   logic        [61:0] rr_in, rr_ff;
   ray_type            ray_in, ray1_ff;

   assign ray_in  = '{ox: req_data.origin_x, oy: req_data.origin_y, dx: req_data.dir_x,
                      dy: req_data.dir_y, tmin: req_data.t_min, tmax: req_data.t_max};
   assign dxx_in  = 64'(64'(req_data.dir_x) * 64'(req_data.dir_x));
   assign dyy_in  = 64'(64'(req_data.dir_y) * 64'(req_data.dir_y));
   assign oxdx_in = 64'(req_data.origin_x) * 64'(req_data.dir_x);
   assign oydy_in = 64'(req_data.origin_y) * 64'(req_data.dir_y);
   assign oxdy_in = 64'(req_data.origin_x) * 64'(req_data.dir_y);
   assign oydx_in = 64'(req_data.origin_y) * 64'(req_data.dir_x);
   assign rr_in   = 62'(req_data.radius) * 62'(req_data.radius);

   // ---- stage 2: a = d.d, h = o.d, |o x d| ----
   logic        [63:0] a_in, a2_ff;
   logic signed [64:0] h_in, h2_ff, cross_w;
   logic        [63:0] cm_in, cm2_ff;
   logic        [61:0] rr2_ff;
   ray_type            ray2_ff;

   assign a_in    = dxx_ff + dyy_ff;
   assign h_in    = 65'(oxdx_ff) + 65'(oydy_ff);
   assign cross_w = 65'(oxdy_ff) - 65'(oydx_ff);
   assign cm_in   = cross_w[64] ? 64'(-cross_w) : cross_w[63:0];

   // ---- stage 3: partial products of a*r^2 and cross^2 ----
   logic [63:0] p00_in, p01_in, p10_in, p11_in, c00_in, c01_in, c11_in;
   logic [63:0] p00_ff, p01_ff, p10_ff, p11_ff, c00_ff, c01_ff, c11_ff;
   logic [63:0] a3_ff;
   logic signed [64:0] h3_ff;
   logic        a_zero3_ff;
   ray_type     ray3_ff;

   assign p00_in = 64'(a2_ff[31:0]) * 64'(rr2_ff[31:0]);
   assign p01_in = 64'(a2_ff[31:0]) * 64'(rr2_ff[61:32]);
   assign p10_in = 64'(a2_ff[63:32]) * 64'(rr2_ff[31:0]);
   assign p11_in = 64'(a2_ff[63:32]) * 64'(rr2_ff[61:32]);
   assign c00_in = 64'(cm2_ff[31:0]) * 64'(cm2_ff[31:0]);
   assign c01_in = 64'(cm2_ff[31:0]) * 64'(cm2_ff[63:32]);
   assign c11_in = 64'(cm2_ff[63:32]) * 64'(cm2_ff[63:32]);

   // ---- stage 4: sum partials ----
   logic [127:0] ar_in, cq_in, ar_ff, cq_ff;
   logic [63:0]  a4_ff;
   logic signed [64:0] h4_ff;
   logic         a_zero4_ff;
   ray_type      ray4_ff;

   assign ar_in = 128'(p00_ff) + (128'(p01_ff) << 32) + (128'(p10_ff) << 32)
                  + (128'(p11_ff) << 64);
   assign cq_in = 128'(c00_ff) + (128'(c01_ff) << 33) + (128'(c11_ff) << 64);

   // ---- stage 5: discriminant h^2 - a*c = a*r^2 - cross^2 ----
   logic [128:0] disc_diff;
   logic [127:0] disc_ff;
   logic [63:0]  a5_ff;
   logic signed [64:0] h5_ff;
   logic         miss5_ff;
   ray_type      ray5_ff;

   assign disc_diff = {1'b0, ar_ff} - {1'b0, cq_ff};

   always_ff @(posedge clock) begin
      dxx_ff     <= dxx_in;
      dyy_ff     <= dyy_in;
      oxdx_ff    <= oxdx_in;
      oydy_ff    <= oydy_in;
      oxdy_ff    <= oxdy_in;
      oydx_ff    <= oydx_in;
      rr_ff      <= rr_in;
      ray1_ff    <= ray_in;
      a2_ff      <= a_in;
      h2_ff      <= h_in;
      cm2_ff     <= cm_in;
      rr2_ff     <= rr_ff;
      ray2_ff    <= ray1_ff;
      p00_ff     <= p00_in;
      p01_ff     <= p01_in;
      p10_ff     <= p10_in;
      p11_ff     <= p11_in;
      c00_ff     <= c00_in;
      c01_ff     <= c01_in;
      c11_ff     <= c11_in;
      a3_ff      <= a2_ff;
      h3_ff      <= h2_ff;
      a_zero3_ff <= (a2_ff == 64'd0);
      ray3_ff    <= ray2_ff;
      ar_ff      <= ar_in;
      cq_ff      <= cq_in;
      a4_ff      <= a3_ff;
      h4_ff      <= h3_ff;
      a_zero4_ff <= a_zero3_ff;
      ray4_ff    <= ray3_ff;
      disc_ff    <= disc_diff[128] ? 128'd0 : disc_diff[127:0];
      a5_ff      <= a4_ff;
      h5_ff      <= h4_ff;
      miss5_ff   <= a_zero4_ff | disc_diff[128];
      ray5_ff    <= ray4_ff;
   end

   // ---- square-root row on the discriminant ----
   logic            s1_v    [0:SQ1];
   logic [65:0]     s1_rem  [0:SQ1];
   logic [63:0]     s1_root [0:SQ1];
   logic [127:0]    s1_rad  [0:SQ1];
   logic [SQ1W-1:0] s1_side [0:SQ1];
   sq1_side_type    s1_head, s1_tail;

   assign s1_head    = '{h: h5_ff, miss: miss5_ff, ray: ray5_ff};
   assign s1_v[0]    = v5_ff;
   assign s1_rem[0]  = '0;
   assign s1_root[0] = '0;
   assign s1_rad[0]  = disc_ff;
   assign s1_side[0] = s1_head;

   // the divisor a rides in its own pipe next to the row
   logic [63:0] a_pipe [0:SQ1];
   assign a_pipe[0] = a5_ff;

   for (genvar i = 0; i < SQ1; i++) begin : g_sq1
      rci_sqrt_cell #(.QW(64), .NW(128), .SW(SQ1W)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_valid (s1_v[i]),
         .in_rem   (s1_rem[i]),
         .in_root  (s1_root[i]),
         .in_rad   (s1_rad[i]),
         .in_side  (s1_side[i]),
         .out_valid(s1_v[i+1]),
         .out_rem  (s1_rem[i+1]),
         .out_root (s1_root[i+1]),
         .out_rad  (s1_rad[i+1]),
         .out_side (s1_side[i+1])
      );
      always_ff @(posedge clock) begin
         a_pipe[i+1] <= a_pipe[i];
      end
   end

   assign s1_tail = sq1_side_type'(s1_side[SQ1]);

   // ---- stage 6: numerators -h -/+ s as sign and magnitude ----
   logic [66:0] n0_in, n1_in;
   logic [64:0] m0_in, m1_in, m0_ff, m1_ff;
   logic [1:0]  neg6_ff;
   logic [63:0] a6_ff;
   logic        miss6_ff;
   ray_type     ray6_ff;

   assign n0_in = 67'(-s1_tail.h) - 67'(s1_root[SQ1]);
   assign n1_in = 67'(-s1_tail.h) + 67'(s1_root[SQ1]);
   assign m0_in = n0_in[66] ? 65'(-n0_in) : n0_in[64:0];
   assign m1_in = n1_in[66] ? 65'(-n1_in) : n1_in[64:0];

   // ---- stage 7: overflow test and divider setup ----
   // quotient bits above 33 only saturate, so they reduce to one compare
   logic [64:0]            hi0, hi1;
   logic [98:0]            lo0, lo1;
   logic [1:0]             big_in;
   logic [1:0][63:0]       rem7_ff;
   logic [1:0][33:0]       nq7_ff;
   logic [1:0]             neg7_ff, big7_ff;
   logic [63:0]            a7_ff;
   logic                   miss7_ff;
   ray_type                ray7_ff;

   assign hi0       = m0_ff >> HI_SHIFT;
   assign hi1       = m1_ff >> HI_SHIFT;
   assign lo0       = 99'(m0_ff) << FRAC_BITS;
   assign lo1       = 99'(m1_ff) << FRAC_BITS;
   assign big_in[0] = (hi0 >= {1'b0, a6_ff});
   assign big_in[1] = (hi1 >= {1'b0, a6_ff});

   always_ff @(posedge clock) begin
      m0_ff      <= m0_in;
      m1_ff      <= m1_in;
      neg6_ff    <= {n1_in[66], n0_in[66]};
      a6_ff      <= a_pipe[SQ1];
      miss6_ff   <= s1_tail.miss;
      ray6_ff    <= s1_tail.ray;
      rem7_ff[0] <= big_in[0] ? 64'd0 : hi0[63:0];
      rem7_ff[1] <= big_in[1] ? 64'd0 : hi1[63:0];
      nq7_ff[0]  <= lo0[33:0];
      nq7_ff[1]  <= lo1[33:0];
      neg7_ff    <= neg6_ff;
      big7_ff    <= big_in;
      a7_ff      <= a6_ff;
      miss7_ff   <= miss6_ff;
      ray7_ff    <= ray6_ff;
   end

   // ---- divider row for both roots, shared divisor a ----
   logic              d1_v    [0:DIV1];
   logic [63:0]       d1_div  [0:DIV1];
   logic [1:0][63:0]  d1_rem  [0:DIV1];
   logic [1:0][33:0]  d1_nq   [0:DIV1];
   logic [DIV1W-1:0]  d1_side [0:DIV1];
   div1_side_type     d1_head, d1_tail;

   assign d1_head    = '{miss: miss7_ff, neg: neg7_ff, big: big7_ff, ray: ray7_ff};
   assign d1_v[0]    = v7_ff;
   assign d1_div[0]  = a7_ff;
   assign d1_rem[0]  = rem7_ff;
   assign d1_nq[0]   = nq7_ff;
   assign d1_side[0] = d1_head;

   for (genvar i = 0; i < DIV1; i++) begin : g_div1
      rci_div_cell #(.DW(64), .NW(34), .LN(2), .SW(DIV1W)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_valid (d1_v[i]),
         .in_div   (d1_div[i]),
         .in_rem   (d1_rem[i]),
         .in_nq    (d1_nq[i]),
         .in_side  (d1_side[i]),
         .out_valid(d1_v[i+1]),
         .out_div  (d1_div[i+1]),
         .out_rem  (d1_rem[i+1]),
         .out_nq   (d1_nq[i+1]),
         .out_side (d1_side[i+1])
      );
   end

   assign d1_tail = div1_side_type'(d1_side[DIV1]);

   // ---- stage 8: floor rounding, clamp to +-2^33, apply sign ----
   logic [1:0][34:0]        qq, tmag;
   logic signed [1:0][35:0] t_in;
   logic signed [35:0]      t0_ff, t1_ff;
   logic                    miss8_ff;
   ray_type                 ray8_ff;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         qq[l]   = 35'(d1_nq[DIV1][l]) + 35'(d1_tail.neg[l] && (d1_rem[DIV1][l] != 64'd0)
                                             && !d1_tail.big[l]);
         tmag[l] = (d1_tail.big[l] || (qq[l] > ROOT_LIMIT)) ? ROOT_LIMIT : qq[l];
         t_in[l] = d1_tail.neg[l] ? -36'(tmag[l]) : 36'(tmag[l]);
      end
   end

   // ---- stage 9: range tests and root choice ----
   logic signed [35:0] tmin_w, tmax_w;
   logic               hit_in;
   logic               hit9_ff;
   logic signed [31:0] th9_ff;
   ray_type            ray9_ff;

   assign tmin_w = 36'(ray8_ff.tmin);
   assign tmax_w = 36'(ray8_ff.tmax);
   assign hit_in = !miss8_ff && !(t0_ff > tmax_w) && !(t1_ff < tmin_w)
                   && !((t0_ff < tmin_w) && (t1_ff > tmax_w));

   // ---- stage 10: t*d ----
   logic signed [63:0] pxm_ff, pym_ff;
   logic               hit10_ff;
   logic signed [31:0] th10_ff, ox10_ff, oy10_ff;

   // ---- stage 11: hit point, floor shift and saturate ----
   logic signed [64:0] sx, sy;
   logic signed [31:0] px_in, py_in, px11_ff, py11_ff, th11_ff;
   logic               hit11_ff;

   assign sx = 65'(ox10_ff) + 65'(pxm_ff >>> FRAC_BITS);
   assign sy = 65'(oy10_ff) + 65'(pym_ff >>> FRAC_BITS);

   always_comb begin
      px_in = sx[31:0];
      py_in = sy[31:0];
      if (sx[64:31] != {34{sx[64]}}) begin
         px_in = sx[64] ? 32'sh80000000 : 32'sh7fffffff;
      end
      if (sy[64:31] != {34{sy[64]}}) begin
         py_in = sy[64] ? 32'sh80000000 : 32'sh7fffffff;
      end
   end

   // ---- stages 12, 13: squared length ----
   logic [63:0]        px2_ff, py2_ff, sq13_ff;
   logic               hit12_ff, hit13_ff;
   logic signed [31:0] th12_ff, px12_ff, py12_ff, th13_ff, px13_ff, py13_ff;

   always_ff @(posedge clock) begin
      t0_ff    <= t_in[0];
      t1_ff    <= t_in[1];
      miss8_ff <= d1_tail.miss;
      ray8_ff  <= d1_tail.ray;
      hit9_ff  <= hit_in;
      th9_ff   <= (t0_ff < tmin_w) ? t1_ff[31:0] : t0_ff[31:0];
      ray9_ff  <= ray8_ff;
      pxm_ff   <= 64'(th9_ff) * 64'(ray9_ff.dx);
      pym_ff   <= 64'(th9_ff) * 64'(ray9_ff.dy);
      hit10_ff <= hit9_ff;
      th10_ff  <= th9_ff;
      ox10_ff  <= ray9_ff.ox;
      oy10_ff  <= ray9_ff.oy;
      px11_ff  <= px_in;
      py11_ff  <= py_in;
      th11_ff  <= th10_ff;
      hit11_ff <= hit10_ff;
      px2_ff   <= 64'(64'(px11_ff) * 64'(px11_ff));
      py2_ff   <= 64'(64'(py11_ff) * 64'(py11_ff));
      hit12_ff <= hit11_ff;
      th12_ff  <= th11_ff;
      px12_ff  <= px11_ff;
      py12_ff  <= py11_ff;
      sq13_ff  <= px2_ff + py2_ff;
      hit13_ff <= hit12_ff;
      th13_ff  <= th12_ff;
      px13_ff  <= px12_ff;
      py13_ff  <= py12_ff;
   end

   // ---- square-root row on the squared length ----
   logic            s2_v    [0:SQ2];
   logic [33:0]     s2_rem  [0:SQ2];
   logic [31:0]     s2_root [0:SQ2];
   logic [63:0]     s2_rad  [0:SQ2];
   logic [SQ2W-1:0] s2_side [0:SQ2];
   sq2_side_type    s2_head, s2_tail;

   assign s2_head    = '{hit: hit13_ff, th: th13_ff, px: px13_ff, py: py13_ff};
   assign s2_v[0]    = v13_ff;
   assign s2_rem[0]  = '0;
   assign s2_root[0] = '0;
   assign s2_rad[0]  = sq13_ff;
   assign s2_side[0] = s2_head;

   for (genvar i = 0; i < SQ2; i++) begin : g_sq2
      rci_sqrt_cell #(.QW(32), .NW(64), .SW(SQ2W)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_valid (s2_v[i]),
         .in_rem   (s2_rem[i]),
         .in_root  (s2_root[i]),
         .in_rad   (s2_rad[i]),
         .in_side  (s2_side[i]),
         .out_valid(s2_v[i+1]),
         .out_rem  (s2_rem[i+1]),
         .out_root (s2_root[i+1]),
         .out_rad  (s2_rad[i+1]),
         .out_side (s2_side[i+1])
      );
   end

   assign s2_tail = sq2_side_type'(s2_side[SQ2]);

   // ---- stage 14: normal divider setup, |p| * 2^30 / len ----
   // |p| <= len, so quotient bits above 30 are zero and the first rem is |p| >> 1
   logic [31:0]       ax, ay;
   logic [1:0][31:0]  rem14_ff;
   logic [1:0][30:0]  nq14_ff;
   logic [31:0]       len14_ff;
   div2_side_type     side14_ff;

   assign ax = s2_tail.px[31] ? 32'(-s2_tail.px) : s2_tail.px;
   assign ay = s2_tail.py[31] ? 32'(-s2_tail.py) : s2_tail.py;

   always_ff @(posedge clock) begin
      rem14_ff[0] <= {1'b0, ax[31:1]};
      rem14_ff[1] <= {1'b0, ay[31:1]};
      nq14_ff[0]  <= {ax[0], 30'd0};
      nq14_ff[1]  <= {ay[0], 30'd0};
      len14_ff    <= s2_root[SQ2];
      side14_ff   <= '{hit: s2_tail.hit, len_zero: (s2_root[SQ2] == 32'd0),
                       neg: {s2_tail.py[31], s2_tail.px[31]},
                       th: s2_tail.th, px: s2_tail.px, py: s2_tail.py};
   end

   // ---- divider row for both normal components, shared divisor len ----
   logic              d2_v    [0:DIV2];
   logic [31:0]       d2_div  [0:DIV2];
   logic [1:0][31:0]  d2_rem  [0:DIV2];
   logic [1:0][30:0]  d2_nq   [0:DIV2];
   logic [DIV2W-1:0]  d2_side [0:DIV2];
   div2_side_type     d2_tail;

   assign d2_v[0]    = v14_ff;
   assign d2_div[0]  = len14_ff;
   assign d2_rem[0]  = rem14_ff;
   assign d2_nq[0]   = nq14_ff;
   assign d2_side[0] = side14_ff;

   for (genvar i = 0; i < DIV2; i++) begin : g_div2
      rci_div_cell #(.DW(32), .NW(31), .LN(2), .SW(DIV2W)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_valid (d2_v[i]),
         .in_div   (d2_div[i]),
         .in_rem   (d2_rem[i]),
         .in_nq    (d2_nq[i]),
         .in_side  (d2_side[i]),
         .out_valid(d2_v[i+1]),
         .out_div  (d2_div[i+1]),
         .out_rem  (d2_rem[i+1]),
         .out_nq   (d2_nq[i+1]),
         .out_side (d2_side[i+1])
      );
   end

   assign d2_tail = div2_side_type'(d2_side[DIV2]);

   // ---- stage 15: signed normal, zero fields on a miss ----
   logic signed [31:0] nx_in, ny_in;
   rci_pkg::rsp_type   rsp_in, rsp_ff;

   always_comb begin
      nx_in = d2_tail.neg[0] ? -32'(d2_nq[DIV2][0]) : 32'(d2_nq[DIV2][0]);
      ny_in = d2_tail.neg[1] ? -32'(d2_nq[DIV2][1]) : 32'(d2_nq[DIV2][1]);
      if (d2_tail.len_zero) begin
         nx_in = '0;
         ny_in = '0;
      end
      rsp_in = '{hit: 1'b1, t_hit: d2_tail.th, hit_x: d2_tail.px, hit_y: d2_tail.py,
                 normal_x: nx_in, normal_y: ny_in};
      if (!d2_tail.hit) begin
         rsp_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // ---- valid bits of the glue stages ----
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         v5_ff  <= 1'b0;
         v6_ff  <= 1'b0;
         v7_ff  <= 1'b0;
         v8_ff  <= 1'b0;
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
         v11_ff <= 1'b0;
         v12_ff <= 1'b0;
         v13_ff <= 1'b0;
         v14_ff <= 1'b0;
         v15_ff <= 1'b0;
      end else begin
         v1_ff  <= accept;
         v2_ff  <= v1_ff;
         v3_ff  <= v2_ff;
         v4_ff  <= v3_ff;
         v5_ff  <= v4_ff;
         v6_ff  <= s1_v[SQ1];
         v7_ff  <= v6_ff;
         v8_ff  <= d1_v[DIV1];
         v9_ff  <= v8_ff;
         v10_ff <= v9_ff;
         v11_ff <= v10_ff;
         v12_ff <= v11_ff;
         v13_ff <= v12_ff;
         v14_ff <= s2_v[SQ2];
         v15_ff <= d2_v[DIV2];
      end
   end

   assign rsp_strobe = v15_ff;
   assign rsp_data   = rsp_ff;

   // ---- checks ----
   `RCI_ASSERT(a_latency, clock, reset, (start && !busy) |-> ##LATENCY rsp_strobe,
               "missing result")
   `RCI_ASSERT(a_no_spurious, clock, reset, rsp_strobe |-> $past(start && !busy, LATENCY),
               "spurious result")
   `RCI_NEVER(a_miss_zero, clock, reset,
              rsp_strobe && !rsp_data.hit && (rsp_data.t_hit != 0 || rsp_data.hit_x != 0
              || rsp_data.hit_y != 0 || rsp_data.normal_x != 0 || rsp_data.normal_y != 0),
              "miss with nonzero fields")
   `RCI_NEVER(a_normal_range, clock, reset,
              rsp_strobe && (rsp_data.normal_x > 32'sd1073741824
              || rsp_data.normal_x < -32'sd1073741824
              || rsp_data.normal_y > 32'sd1073741824
              || rsp_data.normal_y < -32'sd1073741824),
              "normal beyond unit length")

endmodule

`default_nettype wire

// ----- dv/ray_circle_checker.sv -----
`default_nettype none

module ray_circle_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  rci_pkg::req_type req_data,
   input  logic             rsp_strobe,
   input  rci_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending,
   output int               hit_count
);

   localparam int F = rci_pkg::FRAC_BITS;
   localparam logic signed [63:0] ROOT_CAP = 64'sd1 <<< 33;

   rci_pkg::rsp_type exp_q[$];
   int               mismatches = 0;

   assign fail_count = mismatches;

   // floored integer sqrt of a 128-bit value
   function automatic logic [63:0] isqrt128(input logic [127:0] v);
      logic [63:0]  r;
      logic [63:0]  c;
      logic [127:0] sq;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         c  = r | (64'd1 << b);
         sq = {64'd0, c} * {64'd0, c};
         if (sq <= v) r = c;
      end
      return r;
   endfunction

   // floor(num * 2^F / a) clamped to +-2^33; num is signed 66-bit
   function automatic logic signed [63:0] root_of(input logic signed [65:0] num,
                                                   input logic [63:0] a);
      logic        neg;
      logic [65:0] mag;
      logic [127:0] scaled;
      logic [127:0] q;
      logic [127:0] rem;
      neg    = num < 0;
      mag    = neg ? -num : num;
      scaled = {62'd0, mag} << F;
      q      = scaled / {64'd0, a};
      rem    = scaled % {64'd0, a};
      if (neg && rem != 0) q = q + 1;
      if (q > 128'(ROOT_CAP)) q = 128'(ROOT_CAP);
      return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
   endfunction

   function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647)  return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic rci_pkg::rsp_type predict_hit(input rci_pkg::req_type r);
      rci_pkg::rsp_type   o;
      logic signed [63:0] ox, oy, dx, dy, tmin, tmax, t0, t1, th, px, py;
      logic signed [127:0] prx, pry;
      logic [63:0]        a, s, len, rad;
      logic signed [65:0] h, crs;
      logic [127:0]       ar, cq;
      o    = '0;
      ox   = r.origin_x;  oy = r.origin_y;
      dx   = r.dir_x;     dy = r.dir_y;
      tmin = r.t_min;     tmax = r.t_max;
      rad  = {33'd0, r.radius};
      a    = dx * dx + dy * dy;
      if (a == 0) return o;
      h   = 66'(ox * dx) + 66'(oy * dy);
      crs = 66'(ox * dy) - 66'(oy * dx);
      ar = {64'd0, a} * {64'd0, rad * rad};
      cq = 128'($unsigned(crs < 0 ? -crs : crs));
      cq = cq * cq;
      if (cq > ar) return o;
      s  = isqrt128(ar - cq);
      t0 = root_of(-h - $signed({2'b00, s}), a);
      t1 = root_of(-h + $signed({2'b00, s}), a);
      if (t0 > tmax || t1 < tmin) return o;
      th = t0;
      if (t0 < tmin) begin
         if (t1 > tmax) return o;
         th = t1;
      end
      // arithmetic shift floors toward minus infinity
      prx = (128'(th) * 128'(dx)) >>> F;
      pry = (128'(th) * 128'(dy)) >>> F;
      px  = sat32(ox + 64'(prx));
      py  = sat32(oy + 64'(pry));
      len = isqrt128({64'd0, 64'(px * px + py * py)});
      o.hit   = 1'b1;
      o.t_hit = th[31:0];
      o.hit_x = px[31:0];
      o.hit_y = py[31:0];
      if (len != 0) begin
         o.normal_x = 32'((px * (64'sd1 <<< 30)) / $signed(len));
         o.normal_y = 32'((py * (64'sd1 <<< 30)) / $signed(len));
      end
      return o;
   endfunction

   always @(posedge clock) begin
      rci_pkg::rsp_type e;
      if (reset) begin
         exp_q.delete();
         hit_count <= 0;
      end else begin
         if (start && !busy) exp_q.push_back(predict_hit(req_data));
         if (rsp_strobe) begin
            if (exp_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected transaction: %p", rsp_data);
            end else begin
               e = exp_q.pop_front();
               if (e.hit) hit_count <= hit_count + 1;
               if (rsp_data !== e) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: exp hit=%0d t=%0d p=(%0d,%0d) n=(%0d,%0d)",
                               " got hit=%0d t=%0d p=(%0d,%0d) n=(%0d,%0d)"},
                        e.hit, e.t_hit, e.hit_x, e.hit_y, e.normal_x, e.normal_y,
                        rsp_data.hit, rsp_data.t_hit, rsp_data.hit_x, rsp_data.hit_y,
                        rsp_data.normal_x, rsp_data.normal_y);
               end
            end
         end
      end
      pending = exp_q.size();
   end
endmodule

`default_nettype wire

// ----- dv/ray_circle_intersect_tb.sv -----
`default_nettype none

module ray_circle_intersect_tb;

   localparam int LATENCY   = 176;
   localparam int DOG_LIMIT = 4 * LATENCY + 2000;
   localparam int ONE       = 1 << rci_pkg::FRAC_BITS;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   rci_pkg::req_type req_data = '0;
   logic             rsp_strobe;
   rci_pkg::rsp_type rsp_data;
   int               fail_count, pending, hit_count;
   int               sent = 0;
   int               quiet_cycles = 0;
   bit               no_gaps = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ray_circle_intersect u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   ray_circle_checker u_chk (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending(pending), .hit_count(hit_count)
   );

   // watchdog: cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= DOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // hold one ray on the port until it is taken; random gaps before it
   task automatic send_ray(input rci_pkg::req_type r);
      while (!no_gaps && $urandom_range(99) < 37) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent++;
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(3))
         0: return $urandom();
         1: return 32'($signed($urandom_range(8 * ONE)) - 4 * ONE);
         2: return 32'($signed($urandom_range(ONE)) - ONE / 2);
         default: return {{16{$urandom_range(1) == 1}}, 16'($urandom())};
      endcase
   endfunction

   // mostly small coordinates and bounded t ranges so that roots land in range
   function automatic rci_pkg::req_type rand_ray();
      rci_pkg::req_type r;
      r.origin_x = rand_word();
      r.origin_y = rand_word();
      r.dir_x    = rand_word();
      r.dir_y    = rand_word();
      r.radius   = ($urandom_range(3) == 0) ? 31'($urandom()) : 31'($urandom_range(4 * ONE));
      if ($urandom_range(9) < 7) begin
         r.t_min = -32'($urandom_range(2 * ONE));
         r.t_max = 32'($urandom_range(8 * ONE));
         if ($urandom_range(9) == 0) r.dir_y = 0;
      end else begin
         r.t_min = $urandom();
         r.t_max = $urandom();
      end
      return r;
   endfunction

   function automatic rci_pkg::req_type mk(input int ox, oy, dx, dy, tn, tx,
                                           input logic [30:0] rad);
      rci_pkg::req_type r;
      r = '{ox, oy, dx, dy, tn, tx, rad};
      return r;
   endfunction

   initial begin
      int n_rand;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: ordinary hit, zero direction, miss, tangent, inside origin,
      // both roots out of range, inverted bounds, entry before t_min, zero radius, field extremes
      send_ray(mk(-4 * ONE, 0, ONE, 0, 0, 10 * ONE, ONE));
      send_ray(mk(-4 * ONE, 0, 0, 0, 0, 10 * ONE, ONE));
      send_ray(mk(-4 * ONE, 3 * ONE, ONE, 0, 0, 10 * ONE, ONE));
      send_ray(mk(-4 * ONE, ONE, ONE, 0, 0, 10 * ONE, ONE));
      send_ray(mk(0, 0, ONE, ONE, 0, 10 * ONE, 2 * ONE));
      send_ray(mk(-4 * ONE, 0, ONE, 0, 0, ONE, ONE));
      send_ray(mk(-4 * ONE, 0, ONE, 0, 10 * ONE, 0, ONE));
      send_ray(mk(-4 * ONE, 0, ONE, 0, 4 * ONE, 10 * ONE, ONE));
      send_ray(mk(0, 0, ONE, 0, 0, ONE, 0));
      send_ray(mk(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h8000_0000, 32'h7fff_ffff, 31'h7fff_ffff));
      send_ray(mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h7fff_ffff, 31'h7fff_ffff));
      send_ray(mk(-1, -1, -1, -1, 32'h8000_0000, 32'h7fff_ffff, 31'h7fff_ffff));
      send_ray(mk(ONE, 0, 1, 0, 32'h8000_0000, 32'h7fff_ffff, 1));
      send_ray(mk(0, -8 * ONE, 0, ONE, 0, 32'h7fff_ffff, 31'h7fff_ffff));
      send_ray(mk(32'h7fff_ffff, 0, 32'h8000_0000, 0, 32'h8000_0000, 32'h7fff_ffff, ONE));

      n_rand = 450;
      for (int i = 0; i < n_rand; i++) begin
         no_gaps = (i >= 150 && i < 230);
         send_ray(rand_ray());
      end
      start <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);

      $display("sent %0d rays (directed extremes plus random), %0d of them hit the circle",
               sent, hit_count);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

`default_nettype wire
